### src/tet_amips_energy_core_macros.svh
// Assertion helpers for the tetrahedron energy core.
`ifndef TET_AMIPS_ENERGY_CORE_MACROS_SVH
`define TET_AMIPS_ENERGY_CORE_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define TAE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define TAE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tae_pkg.sv
package tae_pkg;

    // Datapath widths
    localparam int CW   = 32;   // input coordinate
    localparam int EW   = 35;   // edge combination vector
    localparam int DFW  = 33;   // coordinate difference
    localparam int SQW  = 66;   // squared difference
    localparam int MW   = 70;   // product of edge terms e1 and e2
    localparam int TRW  = 105;  // triple product
    localparam int DW   = 108;  // determinant
    localparam int D2W  = 216;  // squared determinant
    localparam int PW   = 70;   // pair-difference sum
    localparam int P2W  = 140;
    localparam int P3W  = 210;
    localparam int TW   = 310;  // root target and running remainder
    localparam int WW   = 408;  // scratch width of one root step
    localparam int QW   = 63;   // root bits
    localparam int TGT_SHIFT = 94;
    localparam int NPAIR = 6;
    localparam int NSQ   = 18;
    localparam int NTERM = 6;

    // Wide products are built from 35-bit pieces
    localparam int LW     = 35;   // piece width
    localparam int DMW    = 105;  // determinant magnitude, three pieces
    localparam int NDL    = 3;    // pieces of the determinant magnitude
    localparam int NPL    = 2;    // pieces of the pair-difference sum
    localparam int NP2L   = 4;    // pieces of its square
    localparam int NFRONT = 11;   // front stages ahead of the root seed

    typedef struct packed {
        logic signed [CW-1:0] p0_x;
        logic signed [CW-1:0] p0_y;
        logic signed [CW-1:0] p0_z;
        logic signed [CW-1:0] p1_x;
        logic signed [CW-1:0] p1_y;
        logic signed [CW-1:0] p1_z;
        logic signed [CW-1:0] p2_x;
        logic signed [CW-1:0] p2_y;
        logic signed [CW-1:0] p2_z;
        logic signed [CW-1:0] p3_x;
        logic signed [CW-1:0] p3_y;
        logic signed [CW-1:0] p3_z;
    } tae_in_t;

    typedef struct packed {
        logic [QW-1:0] energy;
        logic          degenerate;
    } tae_out_t;

    // One cube-root step: remainder, q*D2, q^2*D2, D2, partial root, degenerate flag
    typedef struct packed {
        logic [TW-1:0]  rem;
        logic [TW-1:0]  q1;
        logic [TW-1:0]  q2;
        logic [D2W-1:0] d2;
        logic [QW-1:0]  q;
        logic           degen;
    } tae_root_t;

endpackage

### src/tet_amips_energy_core.sv
// AMIPS conformal energy of one tetrahedron per word, fully pipelined: a new
// word may enter every cycle unless the pipe is stalled, and each result passes
// 12 front stages that form the determinant and the pair-difference sum,
// square both and cube the sum from products of 35-bit pieces and seed the
// root, then one stage per bit of the 63-bit bit-serial cube root. Throughput
// is one word per cycle while m_ready is high, and the whole pipe holds in
// place when the result register is full and not taken.
// energy is unsigned Q31.32 rounded toward zero and saturates at all ones;
// degenerate flags a zero determinant, which also returns all ones.
module tet_amips_energy_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tae_pkg::tae_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tae_pkg::tae_out_t m_data
);

    `include "tet_amips_energy_core_macros.svh"

    localparam int CW     = tae_pkg::CW;
    localparam int EW     = tae_pkg::EW;
    localparam int DFW    = tae_pkg::DFW;
    localparam int SQW    = tae_pkg::SQW;
    localparam int MW     = tae_pkg::MW;
    localparam int TRW    = tae_pkg::TRW;
    localparam int DW     = tae_pkg::DW;
    localparam int D2W    = tae_pkg::D2W;
    localparam int PW     = tae_pkg::PW;
    localparam int P2W    = tae_pkg::P2W;
    localparam int P3W    = tae_pkg::P3W;
    localparam int TW     = tae_pkg::TW;
    localparam int WW     = tae_pkg::WW;
    localparam int QW     = tae_pkg::QW;
    localparam int LW     = tae_pkg::LW;
    localparam int LPW    = 2 * tae_pkg::LW;
    localparam int TLW    = tae_pkg::MW + 1;
    localparam int DMW    = tae_pkg::DMW;
    localparam int NDL    = tae_pkg::NDL;
    localparam int NPL    = tae_pkg::NPL;
    localparam int NP2L   = tae_pkg::NP2L;
    localparam int NFRONT = tae_pkg::NFRONT;

    logic en;
    logic signed [CW-1:0] pc [4][3];

    // Valid bits of the front stages
    logic [NFRONT-1:0] fv_reg;

    // Stage 1: input word
    tae_pkg::tae_in_t in_reg;

    // Stage 2: edge vectors and differences
    logic signed [EW-1:0]  e1_reg [3];
    logic signed [EW-1:0]  e2_reg [3];
    logic signed [EW-1:0]  e3_reg [3];
    logic signed [DFW-1:0] dif_reg [tae_pkg::NSQ];

    // Stage 3: pair products and squares
    logic signed [MW-1:0] m_reg [tae_pkg::NTERM];
    logic signed [EW-1:0] e3s_reg [tae_pkg::NTERM];
    logic [SQW-1:0]       sq_reg [tae_pkg::NSQ];

    // Stage 4: upper and lower halves of the triple products, per-axis sums
    logic signed [MW-1:0]  th_reg [tae_pkg::NTERM];
    logic signed [TLW-1:0] tl_reg [tae_pkg::NTERM];
    logic [PW-1:0]         ps_reg [3];

    // Stage 5: triple products and pair sum
    logic signed [TRW-1:0] tri_reg [tae_pkg::NTERM];
    logic [PW-1:0]         p5_reg;

    // Stage 6: determinant
    logic signed [DW-1:0] d_reg;
    logic [PW-1:0]        p6_reg;

    // Stage 7: determinant magnitude
    logic [DMW-1:0] dmag_reg;
    logic [PW-1:0]  p7_reg;

    // Stage 8: partial products of both squares
    logic [LPW-1:0] dp_reg [NDL][NDL];
    logic [LPW-1:0] pp_reg [NPL][NPL];
    logic [PW-1:0]  p8_reg;

    // Stage 9: squares
    logic [D2W-1:0] d2_9_reg;
    logic [P2W-1:0] p2_reg;
    logic [PW-1:0]  p9_reg;

    // Stage 10: partial products of the cube
    logic [D2W-1:0] d2_10_reg;
    logic [LPW-1:0] qp_reg [NP2L][NPL];

    // Stage 11: cube
    logic [D2W-1:0] d2_11_reg;
    logic [P3W-1:0] p3_reg;

    // Root stages; index 0 holds the target, index QW the finished root
    logic                rv_reg [QW+1];
    tae_pkg::tae_root_t  rt_reg [QW+1];

    logic signed [EW-1:0]  e1_next [3];
    logic signed [EW-1:0]  e2_next [3];
    logic signed [EW-1:0]  e3_next [3];
    logic signed [DFW-1:0] dif_next [tae_pkg::NSQ];
    logic signed [MW-1:0]  m_next [tae_pkg::NTERM];
    logic signed [EW-1:0]  e3s_next [tae_pkg::NTERM];
    logic [SQW-1:0]        sq_next [tae_pkg::NSQ];
    logic signed [MW-1:0]  th_next [tae_pkg::NTERM];
    logic signed [TLW-1:0] tl_next [tae_pkg::NTERM];
    logic [PW-1:0]         ps_next [3];
    logic signed [TRW-1:0] tri_next [tae_pkg::NTERM];
    logic [PW-1:0]         p5_next;
    logic signed [DW-1:0]  d_next;
    logic [DMW-1:0]        dmag_next;
    logic [LPW-1:0]        dp_next [NDL][NDL];
    logic [LPW-1:0]        pp_next [NPL][NPL];
    logic [D2W-1:0]        d2_next;
    logic [P2W-1:0]        p2_next;
    logic [LPW-1:0]        qp_next [NP2L][NPL];
    logic [P3W-1:0]        p3_next;
    tae_pkg::tae_root_t    rt0_next;

    // Advance the whole pipe unless the result register is blocked
    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = rv_reg[QW];
    assign m_data.energy     = rt_reg[QW].q;
    assign m_data.degenerate = rt_reg[QW].degen;

    // Unpack coordinates
    always_comb begin
        pc[0][0] = in_reg.p0_x; pc[0][1] = in_reg.p0_y; pc[0][2] = in_reg.p0_z;
        pc[1][0] = in_reg.p1_x; pc[1][1] = in_reg.p1_y; pc[1][2] = in_reg.p1_z;
        pc[2][0] = in_reg.p2_x; pc[2][1] = in_reg.p2_y; pc[2][2] = in_reg.p2_z;
        pc[3][0] = in_reg.p3_x; pc[3][1] = in_reg.p3_y; pc[3][2] = in_reg.p3_z;
    end

    // Form edge combinations and the six vertex-pair differences per axis
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            e1_next[c] = EW'(pc[0][c]) - EW'(pc[3][c]);
            e2_next[c] = EW'(pc[0][c]) - (EW'(pc[1][c]) <<< 1) + EW'(pc[3][c]);
            e3_next[c] = EW'(pc[0][c]) + EW'(pc[1][c]) + EW'(pc[3][c])
                       - (EW'(pc[2][c]) <<< 1) - EW'(pc[2][c]);
            dif_next[c*6+0] = DFW'(pc[0][c]) - DFW'(pc[1][c]);
            dif_next[c*6+1] = DFW'(pc[0][c]) - DFW'(pc[2][c]);
            dif_next[c*6+2] = DFW'(pc[0][c]) - DFW'(pc[3][c]);
            dif_next[c*6+3] = DFW'(pc[1][c]) - DFW'(pc[2][c]);
            dif_next[c*6+4] = DFW'(pc[1][c]) - DFW'(pc[3][c]);
            dif_next[c*6+5] = DFW'(pc[2][c]) - DFW'(pc[3][c]);
        end
    end

    // Multiply the first two factors of each determinant term; square differences
    always_comb begin
        m_next[0] = MW'(e1_reg[0]) * MW'(e2_reg[1]); e3s_next[0] = e3_reg[2];
        m_next[1] = MW'(e1_reg[1]) * MW'(e2_reg[2]); e3s_next[1] = e3_reg[0];
        m_next[2] = MW'(e1_reg[2]) * MW'(e2_reg[0]); e3s_next[2] = e3_reg[1];
        m_next[3] = MW'(e1_reg[0]) * MW'(e2_reg[2]); e3s_next[3] = e3_reg[1];
        m_next[4] = MW'(e1_reg[1]) * MW'(e2_reg[0]); e3s_next[4] = e3_reg[2];
        m_next[5] = MW'(e1_reg[2]) * MW'(e2_reg[1]); e3s_next[5] = e3_reg[0];
        for (int k = 0; k < tae_pkg::NSQ; k++) begin
            sq_next[k] = SQW'(SQW'(dif_reg[k]) * SQW'(dif_reg[k]));
        end
    end

    // Multiply the third factor by each half of the pair product; sum per axis
    always_comb begin
        for (int k = 0; k < tae_pkg::NTERM; k++) begin
            th_next[k] = MW'($signed(m_reg[k][MW-1:LW])) * MW'(e3s_reg[k]);
            tl_next[k] = TLW'($signed({1'b0, m_reg[k][LW-1:0]})) * TLW'(e3s_reg[k]);
        end
        for (int c = 0; c < 3; c++) begin
            ps_next[c] = '0;
            for (int k = 0; k < tae_pkg::NPAIR; k++) begin
                ps_next[c] = ps_next[c] + PW'(sq_reg[c*tae_pkg::NPAIR+k]);
            end
        end
    end

    // Join the halves of each triple product; total the axis sums
    always_comb begin
        for (int k = 0; k < tae_pkg::NTERM; k++) begin
            tri_next[k] = (TRW'(th_reg[k]) <<< LW) + TRW'(tl_reg[k]);
        end
        p5_next = ps_reg[0] + ps_reg[1] + ps_reg[2];
    end

    // Sum the determinant: first three terms add, last three subtract; take the magnitude of the registered determinant
    always_comb begin
        d_next = DW'(tri_reg[0]) + DW'(tri_reg[1]) + DW'(tri_reg[2])
               - DW'(tri_reg[3]) - DW'(tri_reg[4]) - DW'(tri_reg[5]);
        dmag_next = d_reg[DW-1] ? DMW'(-d_reg) : DMW'(d_reg);
    end

    // Partial products of D^2 and P^2
    always_comb begin
        for (int i = 0; i < NDL; i++) begin
            for (int j = 0; j < NDL; j++) begin
                dp_next[i][j] = LPW'(dmag_reg[i*LW +: LW]) * LPW'(dmag_reg[j*LW +: LW]);
            end
        end
        for (int i = 0; i < NPL; i++) begin
            for (int j = 0; j < NPL; j++) begin
                pp_next[i][j] = LPW'(p7_reg[i*LW +: LW]) * LPW'(p7_reg[j*LW +: LW]);
            end
        end
    end

    // Add up the partial products of both squares
    always_comb begin
        d2_next = '0;
        for (int i = 0; i < NDL; i++) begin
            for (int j = 0; j < NDL; j++) begin
                d2_next = d2_next + (D2W'(dp_reg[i][j]) << (LW * (i + j)));
            end
        end
        p2_next = '0;
        for (int i = 0; i < NPL; i++) begin
            for (int j = 0; j < NPL; j++) begin
                p2_next = p2_next + (P2W'(pp_reg[i][j]) << (LW * (i + j)));
            end
        end
    end

    // Partial products of P^3
    always_comb begin
        for (int a = 0; a < NP2L; a++) begin
            for (int b = 0; b < NPL; b++) begin
                qp_next[a][b] = LPW'(p2_reg[a*LW +: LW]) * LPW'(p9_reg[b*LW +: LW]);
            end
        end
    end

    // Add up the partial products of the cube
    always_comb begin
        p3_next = '0;
        for (int a = 0; a < NP2L; a++) begin
            for (int b = 0; b < NPL; b++) begin
                p3_next = p3_next + (P3W'(qp_reg[a][b]) << (LW * (a + b)));
            end
        end
    end

    // Seed the root: target is 9 * P^3 * 2^94
    always_comb begin
        rt0_next.rem   = ((TW'(p3_reg) << 3) + TW'(p3_reg)) << tae_pkg::TGT_SHIFT;
        rt0_next.q1    = '0;
        rt0_next.q2    = '0;
        rt0_next.d2    = d2_11_reg;
        rt0_next.q     = '0;
        rt0_next.degen = (d2_11_reg == '0);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg    <= '0;
            rv_reg[0] <= 1'b0;
        end else if (en) begin
            fv_reg    <= {fv_reg[NFRONT-2:0], s_valid};
            rv_reg[0] <= fv_reg[NFRONT-1];
        end
    end

    // Front payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg    <= s_data;
            e1_reg    <= e1_next;
            e2_reg    <= e2_next;
            e3_reg    <= e3_next;
            dif_reg   <= dif_next;
            m_reg     <= m_next;
            e3s_reg   <= e3s_next;
            sq_reg    <= sq_next;
            th_reg    <= th_next;
            tl_reg    <= tl_next;
            ps_reg    <= ps_next;
            tri_reg   <= tri_next;
            p5_reg    <= p5_next;
            d_reg     <= d_next;
            p6_reg    <= p5_reg;
            dmag_reg  <= dmag_next;
            p7_reg    <= p6_reg;
            dp_reg    <= dp_next;
            pp_reg    <= pp_next;
            p8_reg    <= p7_reg;
            d2_9_reg  <= d2_next;
            p2_reg    <= p2_next;
            p9_reg    <= p8_reg;
            d2_10_reg <= d2_9_reg;
            qp_reg    <= qp_next;
            d2_11_reg <= d2_10_reg;
            p3_reg    <= p3_next;
            rt_reg[0] <= rt0_next;
        end
    end

    // One root bit per stage, from the top bit down. With q1 = q*D2 and
    // q2 = q^2*D2, trying q + 2^b costs 3*q2*2^b + 3*q1*4^b + D2*8^b.
    for (genvar i = 0; i < QW; i++) begin : g_root
        localparam int B = QW - 1 - i;
        logic [WW-1:0] t_q2;
        logic [WW-1:0] t_q1;
        logic [WW-1:0] t_d2;
        logic [WW-1:0] tot;
        logic          fit;
        tae_pkg::tae_root_t nxt;

        always_comb begin
            t_q2 = ((WW'(rt_reg[i].q2) << 1) + WW'(rt_reg[i].q2)) << B;
            t_q1 = ((WW'(rt_reg[i].q1) << 1) + WW'(rt_reg[i].q1)) << (2 * B);
            t_d2 = WW'(rt_reg[i].d2) << (3 * B);
            tot  = t_q2 + t_q1 + t_d2;
            fit  = (tot <= WW'(rt_reg[i].rem));
            nxt  = rt_reg[i];
            if (fit) begin
                nxt.rem  = rt_reg[i].rem - TW'(tot);
                nxt.q2   = TW'(WW'(rt_reg[i].q2) + (WW'(rt_reg[i].q1) << (B + 1))
                         + (WW'(rt_reg[i].d2) << (2 * B)));
                nxt.q1   = TW'(WW'(rt_reg[i].q1) + (WW'(rt_reg[i].d2) << B));
                nxt.q[B] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[i+1] <= 1'b0;
            end else if (en) begin
                rv_reg[i+1] <= rv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rt_reg[i+1] <= nxt;
            end
        end
    end

    `TAE_ASSERT_IMP(a_degen_sat, m_valid && m_data.degenerate, m_data.energy == '1, "degenerate result not saturated")
    `TAE_ASSERT_NXT(a_enter, s_valid && s_ready, fv_reg[0], "accepted word did not enter the pipe")
    `TAE_ASSERT_NXT(a_freeze, !s_ready, $stable(rv_reg[0]) && $stable(fv_reg), "pipe moved while stalled")

endmodule
